// ----- hw/rtl/free_list_keyed_slot_table_assert.svh -----
// Assertion macros shared by the slot table RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef FREE_LIST_KEYED_SLOT_TABLE_ASSERT_SVH
`define FREE_LIST_KEYED_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication.
`define FKST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define FKST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/fkst_pkg.sv -----
// ----------------------------------------------------------------------------
// fkst_pkg
// Widths, operation and status codes for the free-list keyed slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fkst_pkg;

  // table geometry
  localparam int SLOTS = 32;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W = $clog2(SLOTS + 1);  // holds SLOTS as the "none" link

  // word field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- hw/rtl/fkst_if.sv -----
// ----------------------------------------------------------------------------
// fkst_req_if / fkst_rsp_if
// Valid/ready channels carrying request and response words of the slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fkst_req_if import fkst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface fkst_rsp_if import fkst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [VAL_W-1:0]    found_value;

  modport source (output valid, output status, output slot, output found_value, input ready);
  modport sink   (input valid, input status, input slot, input found_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/free_list_keyed_slot_table.sv -----
// ----------------------------------------------------------------------------
// free_list_keyed_slot_table
// Keyed slot table with a linked free list: insert, delete and lookup.
// ----------------------------------------------------------------------------
//  channel | dir | word fields
//  --------+-----+-------------------------------
//  req_i   | in  | kind, key, value
//  rsp_o   | out | status, slot, found_value
//
//  Insert: the result passes through ST_RESP into the response register (free-list
//  head in flops). Delete/lookup: one key compare per cycle over the key memory,
//  lowest slot first; a hit ends the scan at that slot, a miss scans every slot;
//  lookup adds the ST_VRD state for the handle memory read.
//  One request at a time; the response register lets the next request start
//  while a result waits on rsp_o. Reset clears valid bits and chains the free links.
`timescale 1ns / 1ps
`default_nettype none
`include "free_list_keyed_slot_table_assert.svh"

module free_list_keyed_slot_table import fkst_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  fkst_req_if.sink  req_i,
  fkst_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_VRD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  // storage
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] slot_valid_q;
  logic [PTR_W-1:0] free_next_q [SLOTS];
  logic [PTR_W-1:0] head_q, head_d;

  // sequencer
  state_e           state_q, state_d;
  kind_e            op_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] cnt_q;
  logic             issue_done_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;

  // pending result
  status_e          res_status_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             res_lookup_q;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [VAL_W-1:0]    out_fv_q;

  logic             acc;
  logic             head_none;
  logic [IDX_W-1:0] head_idx;
  logic [PTR_W-1:0] nx_link;
  logic [PTR_W-1:0] head_link;
  logic             ins_ok;
  logic             hit;
  logic             scan_last;
  logic             del_hit;
  logic             out_load;

  // handshake and free-list head
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign head_none   = (head_q >= PTR_W'(SLOTS));
  assign head_idx    = head_q[IDX_W-1:0];
  assign nx_link     = (free_next_q[head_idx] > PTR_W'(SLOTS)) ? PTR_W'(SLOTS)
                                                               : free_next_q[head_idx];
  assign head_link   = (head_q > PTR_W'(SLOTS)) ? PTR_W'(SLOTS) : head_q;
  assign ins_ok      = acc && (req_i.kind == KIND_INSERT) && !head_none;

  // shared comparator: one stored key per cycle
  assign hit       = (state_q == ST_SCAN) && cmp_vld_q && slot_valid_q[cmp_idx_q]
                     && (key_rd_q == key_q);
  assign scan_last = cmp_vld_q && (cmp_idx_q == IDX_W'(SLOTS - 1));
  assign del_hit   = hit && (op_q == KIND_DELETE);
  assign out_load  = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);

  // next state and head
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (req_i.kind == KIND_INSERT) begin
            state_d = ST_RESP;
            if (!head_none) begin
              head_d = nx_link;
            end
          end else if (req_i.kind == KIND_DELETE || req_i.kind == KIND_LOOKUP) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (op_q == KIND_LOOKUP) begin
            state_d = ST_VRD;
          end else begin
            state_d = ST_RESP;
            head_d  = PTR_W'(cmp_idx_q);
          end
        end else if (scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_VRD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state, valid bits and free links
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      slot_valid_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        free_next_q[i] <= PTR_W'(i + 1);
      end
      cnt_q        <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (ins_ok) begin
        slot_valid_q[head_idx] <= 1'b1;
      end
      if (del_hit) begin
        slot_valid_q[cmp_idx_q] <= 1'b0;
        free_next_q[cmp_idx_q]  <= head_link;
      end
      // scan address issue
      if (acc) begin
        cnt_q        <= '0;
        issue_done_q <= 1'b0;
        cmp_vld_q    <= 1'b0;
      end else if (state_q == ST_SCAN && !issue_done_q) begin
        cnt_q        <= cnt_q + IDX_W'(1);
        issue_done_q <= (cnt_q == IDX_W'(SLOTS - 1));
        cmp_vld_q    <= 1'b1;
        cmp_idx_q    <= cnt_q;
      end else begin
        cmp_vld_q    <= 1'b0;
      end
      // response register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture and pending result
  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q <= req_i.key;
      if (req_i.kind == KIND_DELETE) begin
        op_q <= KIND_DELETE;
      end else if (req_i.kind == KIND_LOOKUP) begin
        op_q <= KIND_LOOKUP;
      end else begin
        op_q <= KIND_INSERT;
      end
      res_lookup_q <= 1'b0;
      if (head_none) begin
        res_idx_q    <= '0;
        res_status_q <= STATUS_FULL;
      end else begin
        res_idx_q    <= head_idx;
        res_status_q <= STATUS_OK;
      end
    end else if (state_q == ST_SCAN) begin
      if (hit) begin
        res_idx_q    <= cmp_idx_q;
        res_status_q <= STATUS_OK;
        res_lookup_q <= (op_q == KIND_LOOKUP);
      end else if (scan_last) begin
        res_idx_q    <= '0;
        res_status_q <= STATUS_NOT_FOUND;
        res_lookup_q <= 1'b0;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOT_W'(res_idx_q);
      out_fv_q     <= res_lookup_q ? val_rd_q : '0;
    end
  end

  // key and handle memories
  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      key_mem[head_idx] <= req_i.key;
      val_mem[head_idx] <= req_i.value;
    end
    key_rd_q <= key_mem[cnt_q];
    val_rd_q <= val_mem[res_idx_q];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.found_value = out_fv_q;

  // checks
  `FKST_ASSERT_NEXT(a_insert_marks_valid, ins_ok, slot_valid_q[$past(head_idx)])
  `FKST_ASSERT_NEXT(a_delete_pushes_head, del_hit,
                    (head_q == PTR_W'($past(cmp_idx_q))) && !slot_valid_q[$past(cmp_idx_q)])
  `FKST_ASSERT_IMP(a_fail_word_zero, rsp_o.valid && (rsp_o.status != STATUS_OK),
                   (rsp_o.slot == '0) && (rsp_o.found_value == '0))

endmodule

`default_nettype wire
